[hw/rtl/rcfe_pkg.sv]
// rcfe_pkg: shared constants, queue entry type and CRC-8 helper for the
// RC channel frame encoder. No dependencies.
`timescale 1ns / 1ps

package rcfe_pkg;

    // Frame header and checksum constants
    localparam logic [7:0]  SYNC_BYTE = 8'hC8;
    localparam logic [7:0]  LEN_BYTE  = 8'd24;
    localparam logic [7:0]  TYPE_BYTE = 8'h16;
    localparam logic [7:0]  CRC_POLY  = 8'hD5;

    // Pulse width limits in microseconds
    localparam logic [11:0] US_MIN = 12'd880;
    localparam logic [11:0] US_MAX = 12'd2150;

    // floor(x / 5) = (x * RECIP_5) >> RECIP_SHIFT, exact for x below 2**18
    localparam logic [15:0] RECIP_5     = 16'd52429;
    localparam int          RECIP_SHIFT = 18;

    localparam logic [3:0]  LAST_CHANNEL = 4'd15;

    // One channel's worth of work handed from front to back
    typedef struct packed {
        logic        header;     // emit sync, length and type first
        logic        two_bytes;  // two payload bytes, else one
        logic        last_ch;    // close the frame with the CRC byte
        logic [15:0] payload;    // first byte in [7:0], second in [15:8]
    } t_run;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/rcfe_front.sv]
// rcfe_front: accepts pulse widths, saturates and scales them to 11 bits,
// packs them into payload bytes and pushes one run per channel.
// Depends on rcfe_pkg.
`timescale 1ns / 1ps

module rcfe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [11:0]         i_pulse_us,
    input  logic                i_q_full,
    output logic                o_push,
    output rcfe_pkg::t_run      o_run
);

    // Stage A: saturated offset times 8
    logic        r_a_valid;
    logic [13:0] r_a_x;
    // Stage B: scaled channel value
    logic        r_b_valid;
    logic [10:0] r_b_v;
    // Packing state
    logic [3:0]  r_pos;
    logic [6:0]  r_left;
    logic [2:0]  r_left_cnt;

    logic        w_b_ready;
    logic        w_a_ready;
    logic [11:0] w_sat;
    logic [10:0] w_diff;
    logic [29:0] w_prod;
    logic [2:0]  w_cnt;
    logic [6:0]  w_left;
    logic [17:0] w_acc;
    logic [4:0]  w_bits;
    logic        w_two;

    // Handshake down the pipe
    assign o_push    = r_b_valid && !i_q_full;
    assign w_b_ready = !r_b_valid || o_push;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    // Saturate the pulse width
    always_comb begin
        w_sat = i_pulse_us;
        if (i_pulse_us < rcfe_pkg::US_MIN) begin
            w_sat = rcfe_pkg::US_MIN;
        end else if (i_pulse_us > rcfe_pkg::US_MAX) begin
            w_sat = rcfe_pkg::US_MAX;
        end
        w_diff = 11'(w_sat - rcfe_pkg::US_MIN);
    end

    // Divide by five through the reciprocal
    assign w_prod = 30'(r_a_x) * 30'(rcfe_pkg::RECIP_5);

    // Append the value to the leftover bits
    always_comb begin
        w_cnt  = (r_pos == '0) ? 3'd0 : r_left_cnt;
        w_left = (r_pos == '0) ? 7'd0 : r_left;
        w_acc  = 18'(w_left) | (18'(r_b_v) << w_cnt);
        w_bits = 5'(w_cnt) + 5'd11;
        w_two  = (w_bits >= 5'd16);
        o_run.header    = (r_pos == '0);
        o_run.two_bytes = w_two;
        o_run.last_ch   = (r_pos == rcfe_pkg::LAST_CHANNEL);
        o_run.payload   = w_acc[15:0];
    end

    // Advance the pipe and the packing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_pos      <= '0;
            r_left     <= '0;
            r_left_cnt <= '0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (o_push) begin
                r_pos <= r_pos + 4'd1;
                if (w_two) begin
                    r_left     <= 7'(w_acc[17:16]);
                    r_left_cnt <= 3'(w_bits - 5'd16);
                end else begin
                    r_left     <= w_acc[14:8];
                    r_left_cnt <= 3'(w_bits - 5'd8);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_x <= {w_diff, 3'b000};
        end
        if (w_b_ready && r_a_valid) begin
            r_b_v <= w_prod[rcfe_pkg::RECIP_SHIFT +: 11];
        end
    end

endmodule

[hw/rtl/rcfe_queue.sv]
// rcfe_queue: small FIFO of channel runs between front and back.
// Depends on rcfe_pkg.
`timescale 1ns / 1ps

module rcfe_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rcfe_pkg::t_run      i_run,
    input  logic                i_pop,
    output rcfe_pkg::t_run      o_head,
    output logic                o_empty,
    output logic                o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    rcfe_pkg::t_run r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

endmodule

[hw/rtl/rcfe_back.sv]
// rcfe_back: expands queued runs into frame bytes, one per cycle while the byte
// port is ready and a run is queued, and keeps the running CRC-8. Depends on rcfe_pkg.
`timescale 1ns / 1ps

module rcfe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rcfe_pkg::t_run      i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_frame_byte,
    output logic                o_run_last,
    output logic                o_frame_end
);

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_LEN,
        PH_TYPE,
        PH_PAY0,
        PH_PAY1,
        PH_CRC
    } t_phase;

    t_phase     r_phase;
    logic       r_busy;
    logic [7:0] r_crc;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_frame_end;

    t_phase     w_cur;
    t_phase     w_next;
    logic       w_load;
    logic       w_step;
    logic       w_done;
    logic [7:0] w_byte;

    assign w_load = !r_valid || i_ready;
    assign w_step = w_load && !i_empty;

    // Pick this cycle's byte and the phase after it
    always_comb begin
        if (r_busy) begin
            w_cur = r_phase;
        end else if (i_head.header) begin
            w_cur = PH_SYNC;
        end else begin
            w_cur = PH_PAY0;
        end
        w_done = 1'b0;
        w_next = w_cur;
        w_byte = rcfe_pkg::SYNC_BYTE;
        unique case (w_cur)
            PH_SYNC: begin
                w_byte = rcfe_pkg::SYNC_BYTE;
                w_next = PH_LEN;
            end
            PH_LEN: begin
                w_byte = rcfe_pkg::LEN_BYTE;
                w_next = PH_TYPE;
            end
            PH_TYPE: begin
                w_byte = rcfe_pkg::TYPE_BYTE;
                w_next = PH_PAY0;
            end
            PH_PAY0: begin
                w_byte = i_head.payload[7:0];
                if (i_head.two_bytes) begin
                    w_next = PH_PAY1;
                end else if (i_head.last_ch) begin
                    w_next = PH_CRC;
                end else begin
                    w_done = 1'b1;
                end
            end
            PH_PAY1: begin
                w_byte = i_head.payload[15:8];
                if (i_head.last_ch) begin
                    w_next = PH_CRC;
                end else begin
                    w_done = 1'b1;
                end
            end
            PH_CRC: begin
                w_byte = r_crc;
                w_done = 1'b1;
            end
            default: begin
                w_byte = rcfe_pkg::SYNC_BYTE;
                w_done = 1'b1;
            end
        endcase
    end

    assign o_pop = w_step && w_done;

    // Hold state, CRC and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC;
            r_busy      <= 1'b0;
            r_crc       <= '0;
            r_valid     <= 1'b0;
            r_byte      <= '0;
            r_run_last  <= 1'b0;
            r_frame_end <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= !i_empty;
            end
            if (w_step) begin
                r_phase     <= w_next;
                r_busy      <= !w_done;
                r_byte      <= w_byte;
                r_run_last  <= w_done;
                r_frame_end <= (w_cur == PH_CRC);
                if (w_cur == PH_TYPE) begin
                    r_crc <= rcfe_pkg::crc8_byte(8'd0, rcfe_pkg::TYPE_BYTE);
                end else if (w_cur == PH_PAY0 || w_cur == PH_PAY1) begin
                    r_crc <= rcfe_pkg::crc8_byte(r_crc, w_byte);
                end
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_run_last   = r_run_last;
    assign o_frame_end  = r_frame_end;

endmodule

[hw/rtl/rc_channel_frame_encoder.sv]
// rc_channel_frame_encoder: top level of the packed RC channel frame encoder.
// Depends on rcfe_pkg, rcfe_front, rcfe_queue and rcfe_back.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------
//   pulse in | input     | i_valid / o_ready  | i_pulse_us[11:0]
//   bytes out| output    | o_valid / i_ready  | o_frame_byte[7:0], o_run_last, o_frame_end
//
// A channel enters on i_valid / o_ready; the front is a pipe (saturate, reciprocal
// multiply, pack) that pushes one run per channel into the queue. The back sends
// one byte per cycle while the byte port is ready and the queue is not empty; a channel
// gives one or two payload bytes, plus sync, length and type on the header channel
// and CRC on the last. Reset is synchronous, active low, and clears all control state.
// A stalled output fills the queue, after which o_ready drops.
`timescale 1ns / 1ps

module rc_channel_frame_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_pulse_us,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_run_last,
    output logic        o_frame_end
);

    rcfe_pkg::t_run w_push_run;
    rcfe_pkg::t_run w_head;
    logic           w_push;
    logic           w_pop;
    logic           w_empty;
    logic           w_full;

    // Saturate, scale and pack channels
    rcfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pulse_us (i_pulse_us),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_run      (w_push_run)
    );

    // Decouple front and back
    rcfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_run   (w_push_run),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Serialise frame bytes
    rcfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_byte (o_frame_byte),
        .o_run_last   (o_run_last),
        .o_frame_end  (o_frame_end)
    );

endmodule
